// File: src/sdcr_pkg.sv
// Shared types and constants of the SD/MMC card command responder.
// Used by the front, queue, sequencer, top level and checker; no dependencies.
package sdcr_pkg;

    // Input opcodes
    localparam logic OP_COMMAND  = 1'b0;
    localparam logic OP_CONTINUE = 1'b1;

    // Bus command indexes
    localparam logic [5:0] CMD_GO_IDLE       = 6'd0;
    localparam logic [5:0] CMD_SEND_OP_COND  = 6'd1;
    localparam logic [5:0] CMD_ALL_SEND_CID  = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA      = 6'd3;
    localparam logic [5:0] CMD_SWITCH        = 6'd6;
    localparam logic [5:0] CMD_SELECT        = 6'd7;
    localparam logic [5:0] CMD_SEND_IF_COND  = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD      = 6'd9;
    localparam logic [5:0] CMD_SEND_CID      = 6'd10;
    localparam logic [5:0] CMD_STOP          = 6'd12;
    localparam logic [5:0] CMD_SEND_STATUS   = 6'd13;
    localparam logic [5:0] CMD_SET_BLOCKLEN  = 6'd16;
    localparam logic [5:0] CMD_READ_MULTI    = 6'd18;
    localparam logic [5:0] CMD_WRITE_MULTI   = 6'd25;
    localparam logic [5:0] CMD_APP           = 6'd55;

    // Application command indexes (after CMD55)
    localparam logic [5:0] ACMD_BUS_WIDTH    = 6'd6;
    localparam logic [5:0] ACMD_SD_STATUS    = 6'd13;
    localparam logic [5:0] ACMD_OP_COND      = 6'd41;
    localparam logic [5:0] ACMD_LOCK         = 6'd42;
    localparam logic [5:0] ACMD_SEND_SCR     = 6'd51;

    // Current-state codes written to status bits 12:9
    localparam logic [3:0] CST_READY = 4'd1;
    localparam logic [3:0] CST_IDENT = 4'd2;
    localparam logic [3:0] CST_TRAN  = 4'd4;
    localparam logic [3:0] CST_DATA  = 4'd5;

    // Multi-block transfer directions
    localparam logic [1:0] XFER_NONE  = 2'd0;
    localparam logic [1:0] XFER_READ  = 2'd1;
    localparam logic [1:0] XFER_WRITE = 2'd2;

    localparam logic [31:0] STATUS_RESET = 32'h0000_0100;
    localparam logic [31:0] OCR_RESET    = 32'h80FF_8000;
    localparam logic [31:0] OCR_KEEP     = 32'hBF00_0000;
    localparam logic [31:0] OCR_TAKE     = 32'h40FF_FFFF;
    localparam int          ACMD_BIT     = 5;
    localparam int          CCS_BIT      = 30;
    localparam logic [9:0]  SECTOR_BYTES = 10'd512;
    localparam logic [31:0] SCR_HIGH     = 32'h012A_0000;
    localparam logic [31:0] RCA_FLAG     = 32'h0001_0000;

    // CSD answer, sent in this order
    localparam logic [31:0] CSD_WORDS [4] = '{
        32'h0090_2601, 32'h2A0F_5901, 32'hDFF6_DB7F, 32'hE996_4040
    };

    localparam int ADDR_W = 41;
    localparam int LEN_W  = 10;
    localparam int STEP_W = 5;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_IS_INTERNAL  = 2'd0;
    localparam logic [1:0] REG_CARD_ID_HIGH = 2'd1;
    localparam logic [1:0] REG_CARD_ID_LOW  = 2'd2;

    typedef enum logic [1:0] {
        KIND_RESP  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_WRITE = 2'd3
    } t_kind;

    // Result sequences the back end plays out
    typedef enum logic [2:0] {
        SEQ_RESP  = 3'd0,   // one response word
        SEQ_CID   = 3'd1,   // four card-id words
        SEQ_CSD   = 3'd2,   // four fixed CSD words
        SEQ_SSR   = 3'd3,   // response plus sixteen zero data words
        SEQ_SCR   = 3'd4,   // response plus two SCR data words
        SEQ_MULTI = 3'd5,   // response plus first block request
        SEQ_BLOCK = 3'd6    // one block request
    } t_seq;

    typedef struct packed {
        t_seq               seq;
        logic [31:0]        word;
        t_kind              blk_kind;
        logic [ADDR_W-1:0]  addr;
        logic [LEN_W-1:0]   len;
    } t_job;

endpackage

// File: src/sdcr_front.sv
// Command front end: accepts items, decodes them, updates card state
// and queues a result job. Depends on sdcr_pkg.
module sdcr_front
    import sdcr_pkg::*;
#(
    parameter int MAX_BLOCK_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [5:0]  i_cmd_index,
    input  logic [31:0] i_argument,
    input  logic        i_is_internal,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [31:0]       r_status, n_status;
    logic [31:0]       r_ocr, n_ocr;
    logic [LEN_W-1:0]  r_blk_bytes, n_blk_bytes;
    logic [ADDR_W-1:0] r_xfer_addr, n_xfer_addr;
    logic [1:0]        r_active, n_active;
    logic              has_result;
    logic              accept;
    logic [31:0]       st_cur;
    logic [31:0]       arg_op;
    logic [ADDR_W-1:0] start_addr;
    logic [LEN_W-1:0]  start_len;

    function automatic logic [31:0] set_state(input logic [31:0] st, input logic [3:0] code);
        logic [31:0] r;
        r = st;
        r[12:9] = code;
        return r;
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && has_result;

    always_comb begin
        n_status    = r_status;
        n_ocr       = r_ocr;
        n_blk_bytes = r_blk_bytes;
        n_xfer_addr = r_xfer_addr;
        n_active    = r_active;
        has_result  = 1'b0;
        o_job.seq      = SEQ_RESP;
        o_job.word     = r_status;
        o_job.blk_kind = (r_active == XFER_READ) ? KIND_READ : KIND_WRITE;
        o_job.addr     = r_xfer_addr;
        o_job.len      = r_blk_bytes;
        st_cur = r_status;
        st_cur[ACMD_BIT] = 1'b0;
        arg_op = i_argument;
        arg_op[CCS_BIT] = 1'b0;
        // high-capacity cards address in sectors
        if (r_ocr[CCS_BIT]) begin
            start_addr = {i_argument, 9'd0};
            start_len  = SECTOR_BYTES;
        end else begin
            start_addr = ADDR_W'(i_argument);
            start_len  = r_blk_bytes;
        end

        if (i_opcode == OP_CONTINUE) begin
            if (r_active == XFER_READ || r_active == XFER_WRITE) begin
                has_result  = 1'b1;
                o_job.seq   = SEQ_BLOCK;
                n_xfer_addr = r_xfer_addr + ADDR_W'(r_blk_bytes);
            end
        end else if (r_status[ACMD_BIT]) begin
            // drop the prefix whatever the command turns out to be
            n_status   = st_cur;
            o_job.word = st_cur;
            case (i_cmd_index)
                ACMD_BUS_WIDTH, ACMD_LOCK: begin
                    has_result = 1'b1;
                end
                ACMD_SD_STATUS: begin
                    has_result = 1'b1;
                    o_job.seq  = SEQ_SSR;
                end
                ACMD_OP_COND: begin
                    has_result = 1'b1;
                    n_ocr = (r_ocr & OCR_KEEP) |
                            ((i_is_internal ? arg_op : i_argument) & OCR_TAKE);
                    o_job.word = n_ocr;
                    n_status   = set_state(st_cur, CST_READY);
                end
                ACMD_SEND_SCR: begin
                    has_result = 1'b1;
                    o_job.seq  = SEQ_SCR;
                end
                default: begin
                end
            endcase
        end else begin
            case (i_cmd_index)
                CMD_GO_IDLE, CMD_SWITCH, CMD_SELECT, CMD_SEND_STATUS: begin
                    has_result = 1'b1;
                end
                CMD_SEND_OP_COND: begin
                    if (i_is_internal) begin
                        has_result = 1'b1;
                        n_ocr      = (r_ocr & OCR_KEEP) | (arg_op & OCR_TAKE);
                        o_job.word = n_ocr;
                        n_status   = set_state(r_status, CST_READY);
                    end
                end
                CMD_ALL_SEND_CID: begin
                    has_result = 1'b1;
                    o_job.seq  = SEQ_CID;
                    n_status   = set_state(r_status, CST_IDENT);
                end
                CMD_SEND_CID: begin
                    has_result = 1'b1;
                    o_job.seq  = SEQ_CID;
                end
                CMD_SEND_RCA: begin
                    has_result = 1'b1;
                    if (i_is_internal) begin
                        o_job.word = r_status | RCA_FLAG;
                    end else begin
                        o_job.word = (r_status & 32'h0000_1FFF) |
                                     ((r_status >> 6) & 32'h0000_2000) |
                                     ((r_status >> 8) & 32'h0000_C000) | RCA_FLAG;
                    end
                end
                CMD_SEND_IF_COND: begin
                    has_result = 1'b1;
                    o_job.word = i_argument;
                end
                CMD_SEND_CSD: begin
                    has_result = 1'b1;
                    o_job.seq  = SEQ_CSD;
                end
                CMD_STOP: begin
                    has_result = 1'b1;
                    n_status   = set_state(r_status, CST_TRAN);
                    n_active   = XFER_NONE;
                    o_job.word = n_status;
                end
                CMD_SET_BLOCKLEN: begin
                    has_result = 1'b1;
                    if (i_argument > 32'(MAX_BLOCK_BYTES)) begin
                        n_blk_bytes = LEN_W'(MAX_BLOCK_BYTES);
                    end else begin
                        n_blk_bytes = i_argument[LEN_W-1:0];
                    end
                    n_status   = set_state(r_status, CST_TRAN);
                    o_job.word = n_status;
                end
                CMD_READ_MULTI, CMD_WRITE_MULTI: begin
                    has_result     = 1'b1;
                    o_job.seq      = SEQ_MULTI;
                    o_job.addr     = start_addr;
                    o_job.len      = start_len;
                    n_blk_bytes    = start_len;
                    n_xfer_addr    = start_addr + ADDR_W'(start_len);
                    if (i_cmd_index == CMD_READ_MULTI) begin
                        o_job.blk_kind = KIND_READ;
                        n_active       = XFER_READ;
                        n_status       = set_state(r_status, CST_DATA);
                    end else begin
                        o_job.blk_kind = KIND_WRITE;
                        n_active       = XFER_WRITE;
                        n_status       = set_state(r_status, CST_TRAN);
                    end
                end
                CMD_APP: begin
                    has_result = 1'b1;
                    n_status   = r_status;
                    n_status[ACMD_BIT] = 1'b1;
                    o_job.word = n_status;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status    <= STATUS_RESET;
            r_ocr       <= OCR_RESET;
            r_blk_bytes <= '0;
            r_xfer_addr <= '0;
            r_active    <= XFER_NONE;
        end else if (accept) begin
            r_status    <= n_status;
            r_ocr       <= n_ocr;
            r_blk_bytes <= n_blk_bytes;
            r_xfer_addr <= n_xfer_addr;
            r_active    <= n_active;
        end
    end

endmodule

// File: src/sdcr_queue.sv
// Two-entry job queue between the command front end and the result sequencer.
// Depends on sdcr_pkg for the job type.
module sdcr_queue
    import sdcr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: src/sdcr_back.sv
// Result sequencer: plays out one queued job as result items, one per cycle while the output
// is not stalled, through a registered output stage. Depends on sdcr_pkg.
module sdcr_back
    import sdcr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  t_job              i_job,
    output logic              o_pop,
    input  logic [63:0]       i_card_id_high,
    input  logic [63:0]       i_card_id_low,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_kind,
    output logic [31:0]       o_word,
    output logic              o_end_of_response,
    output logic [ADDR_W-1:0] o_block_address,
    output logic [LEN_W-1:0]  o_block_length,
    output logic              o_last
);

    t_job              r_job;
    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    t_kind             r_kind;
    logic [31:0]       r_word;
    logic              r_eor;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;
    logic              r_last;

    logic              emit;
    logic              step_last;
    logic              load;
    logic [STEP_W-1:0] last_step;
    t_kind             g_kind;
    logic [31:0]       g_word;
    logic              g_eor;
    logic [ADDR_W-1:0] g_addr;
    logic [LEN_W-1:0]  g_len;

    always_comb begin
        case (r_job.seq)
            SEQ_CID, SEQ_CSD: last_step = STEP_W'(3);
            SEQ_SSR:          last_step = STEP_W'(16);
            SEQ_SCR:          last_step = STEP_W'(2);
            SEQ_MULTI:        last_step = STEP_W'(1);
            default:          last_step = '0;
        endcase
    end

    assign emit      = r_busy && (!r_out_valid || i_ready);
    assign step_last = (r_step == last_step);
    // take the next job in the cycle the current one ends
    assign load      = i_job_valid && (!r_busy || (emit && step_last));
    assign o_pop     = load;

    always_comb begin
        g_kind = KIND_RESP;
        g_word = '0;
        g_eor  = 1'b0;
        g_addr = '0;
        g_len  = '0;
        case (r_job.seq)
            SEQ_RESP: begin
                g_word = r_job.word;
                g_eor  = 1'b1;
            end
            SEQ_CID: begin
                case (r_step[1:0])
                    2'd0:    g_word = i_card_id_high[63:32];
                    2'd1:    g_word = i_card_id_high[31:0];
                    2'd2:    g_word = i_card_id_low[63:32];
                    default: g_word = i_card_id_low[31:0];
                endcase
                g_eor = step_last;
            end
            SEQ_CSD: begin
                g_word = CSD_WORDS[r_step[1:0]];
                g_eor  = step_last;
            end
            SEQ_SSR, SEQ_SCR: begin
                if (r_step == '0) begin
                    g_word = r_job.word;
                    g_eor  = 1'b1;
                end else begin
                    g_kind = KIND_DATA;
                    if (r_job.seq == SEQ_SCR && r_step == STEP_W'(1)) begin
                        g_word = SCR_HIGH;
                    end
                end
            end
            SEQ_MULTI: begin
                if (r_step == '0) begin
                    g_word = r_job.word;
                    g_eor  = 1'b1;
                end else begin
                    g_kind = r_job.blk_kind;
                    g_addr = r_job.addr;
                    g_len  = r_job.len;
                end
            end
            default: begin
                g_kind = r_job.blk_kind;
                g_addr = r_job.addr;
                g_len  = r_job.len;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_kind <= g_kind;
            r_word <= g_word;
            r_eor  <= g_eor;
            r_addr <= g_addr;
            r_len  <= g_len;
            r_last <= step_last;
        end
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (emit) begin
                if (step_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + STEP_W'(1);
                end
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_kind            = r_kind;
    assign o_word            = r_word;
    assign o_end_of_response = r_eor;
    assign o_block_address   = r_addr;
    assign o_block_length    = r_len;
    assign o_last            = r_last;

endmodule

// File: src/sd_mmc_card_command_responder.sv
// Card side of an SD/MMC command bus. An input item is accepted in any cycle in which the
// two-entry job queue has room, so items may follow back to back; the front end decodes the
// command and updates card state at acceptance. The result sequencer then emits one result item
// per cycle from a registered output stage unless i_ready stalls it; an item causes 1 to 17
// results, and that sequencer sets the sustained rate. Commands with no result produce nothing.
// Configuration registers (is_internal, card id high, card id low) sit at byte addresses 0, 8
// and 16 of the 64-bit port; the user must see that they are written only while the block is
// idle; the block does not enforce this. Depends on sdcr_pkg, sdcr_front, sdcr_queue and sdcr_back.
module sd_mmc_card_command_responder
    import sdcr_pkg::*;
#(
    parameter int MAX_BLOCK_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [5:0]  i_cmd_index,
    input  logic [31:0] i_argument,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_word,
    output logic        o_end_of_response,
    output logic [40:0] o_block_address,
    output logic [9:0]  o_block_length,
    output logic        o_last
);

    logic        r_is_internal;
    logic [63:0] r_card_id_high;
    logic [63:0] r_card_id_low;
    logic        cfg_write;
    logic [1:0]  reg_index;

    logic        push;
    t_job        push_job;
    logic        q_full;
    logic        q_valid;
    t_job        q_job;
    logic        pop;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_internal  <= 1'b0;
            r_card_id_high <= '0;
            r_card_id_low  <= '0;
        end else if (cfg_write) begin
            case (reg_index)
                REG_IS_INTERNAL:  r_is_internal  <= pwdata[0];
                REG_CARD_ID_HIGH: r_card_id_high <= pwdata;
                REG_CARD_ID_LOW:  r_card_id_low  <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_IS_INTERNAL:  prdata = {63'd0, r_is_internal};
            REG_CARD_ID_HIGH: prdata = r_card_id_high;
            REG_CARD_ID_LOW:  prdata = r_card_id_low;
            default:          prdata = '0;
        endcase
    end

    sdcr_front #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_cmd_index   (i_cmd_index),
        .i_argument    (i_argument),
        .i_is_internal (r_is_internal),
        .i_full        (q_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    sdcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    sdcr_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job_valid       (q_valid),
        .i_job             (q_job),
        .o_pop             (pop),
        .i_card_id_high    (r_card_id_high),
        .i_card_id_low     (r_card_id_low),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_kind            (o_kind),
        .o_word            (o_word),
        .o_end_of_response (o_end_of_response),
        .o_block_address   (o_block_address),
        .o_block_length    (o_block_length),
        .o_last            (o_last)
    );

endmodule

// File: src/sdcr_checker.sv
// Port-level checks on the result channel of the command responder.
// Depends on sdcr_pkg; bound to sd_mmc_card_command_responder below.
module sdcr_port_checks
    import sdcr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_kind,
    input logic [31:0] o_word,
    input logic        o_end_of_response,
    input logic [40:0] o_block_address,
    input logic [9:0]  o_block_length,
    input logic        o_last
);

    // stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_word) && $stable(o_kind) && $stable(o_last))
        else $error("result changed while stalled");

    a_block_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_READ || o_kind == KIND_WRITE)
            |-> o_word == '0 && !o_end_of_response)
        else $error("block request carries a word or end marker");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_DATA
            |-> o_block_address == '0 && o_block_length == '0 && !o_end_of_response)
        else $error("data word carries block fields");

    // a response ending an item's results must be its final word
    a_last_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_RESP && o_last |-> o_end_of_response)
        else $error("last response word without end marker");

endmodule

bind sd_mmc_card_command_responder sdcr_port_checks u_sdcr_port_checks (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_kind            (o_kind),
    .o_word            (o_word),
    .o_end_of_response (o_end_of_response),
    .o_block_address   (o_block_address),
    .o_block_length    (o_block_length),
    .o_last            (o_last)
);
